[src/cfe_pkg.sv]
// Package for the COBS frame encoder.
// Holds the shared widths, register indexes, the job record and the position helper.
// No dependencies.
package cfe_pkg;

    localparam int POS_W       = 13;
    localparam int BYTE_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int QUEUE_DEPTH = 4;
    localparam int SLOTS       = 4;
    localparam int DEFAULT_BUFFER_DEPTH = 4096;
    localparam int TDATA_OUT_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY = 2'd2;

    localparam logic [BYTE_W-1:0] RST_DELIMITER    = 8'd0;
    localparam logic [BYTE_W-1:0] RST_MAX_COUNT    = 8'd255;
    localparam logic [POS_W-1:0]  RST_OUT_CAPACITY = 13'd4096;

    // Write slots of one job, in the order they go out.
    localparam int SLOT_DATA  = 0;
    localparam int SLOT_PATCH = 1;
    localparam int SLOT_FINAL = 2;
    localparam int SLOT_TRAIL = 3;

    typedef struct packed {
        logic [SLOTS-1:0]  mask;
        logic [POS_W-1:0]  data_addr;
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  patch_addr;
        logic [BYTE_W-1:0] patch_code;
        logic [POS_W-1:0]  final_addr;
        logic [BYTE_W-1:0] final_code;
        logic [POS_W-1:0]  trail_addr;
        logic [BYTE_W-1:0] trail_byte;
        logic [POS_W-1:0]  trail_len;
    } job_t;

    // Increment a position that never exceeds lim, saturating at lim.
    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] pos,
                                                 input logic [POS_W-1:0] lim);
        logic [POS_W-1:0] r;
        r = (pos >= lim) ? lim : pos + 1'b1;
        return r;
    endfunction

endpackage

[src/cfe_front.sv]
// Front end of the COBS frame encoder: accepts raw bytes and turns each into a job.
// Keeps the code position, run count and next position. Depends on cfe_pkg.
module cfe_front #(
    parameter logic [cfe_pkg::POS_W-1:0] POS_LIMIT =
        cfe_pkg::POS_W'(cfe_pkg::DEFAULT_BUFFER_DEPTH)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic [cfe_pkg::BYTE_W-1:0]  data_byte,
    input  logic                        frame_last,
    input  logic [cfe_pkg::BYTE_W-1:0]  delimiter,
    input  logic [cfe_pkg::BYTE_W-1:0]  max_count,
    output cfe_pkg::job_t               job
);

    logic [cfe_pkg::POS_W-1:0]  code_pos_reg, code_pos_next;
    logic [cfe_pkg::POS_W-1:0]  next_pos_reg, next_pos_next;
    logic [cfe_pkg::BYTE_W-1:0] run_cnt_reg, run_cnt_next;

    logic [cfe_pkg::BYTE_W-1:0] limit;
    logic [cfe_pkg::BYTE_W-1:0] rc1;
    logic [cfe_pkg::POS_W-1:0]  np1;
    logic [cfe_pkg::POS_W-1:0]  cp2, np2;
    logic [cfe_pkg::BYTE_W-1:0] rc2;

    always_comb begin
        limit = (max_count < 8'd2) ? 8'd255 : max_count;
        rc1   = run_cnt_reg + 8'd1;
        np1   = cfe_pkg::sat_inc(next_pos_reg, POS_LIMIT);
        job   = '0;
        cp2   = code_pos_reg;
        np2   = next_pos_reg;
        rc2   = run_cnt_reg;

        if (data_byte != delimiter) begin
            job.mask[cfe_pkg::SLOT_DATA] = 1'b1;
            job.data_addr = next_pos_reg;
            job.data_byte = data_byte;
            if (rc1 >= limit) begin
                // Run is full: back-patch its code byte and open a new block.
                job.mask[cfe_pkg::SLOT_PATCH] = 1'b1;
                job.patch_addr = code_pos_reg;
                job.patch_code = rc1;
                cp2 = np1;
                np2 = cfe_pkg::sat_inc(np1, POS_LIMIT);
                rc2 = 8'd1;
            end else begin
                np2 = np1;
                rc2 = rc1;
            end
        end else begin
            job.mask[cfe_pkg::SLOT_PATCH] = 1'b1;
            job.patch_addr = code_pos_reg;
            job.patch_code = run_cnt_reg;
            cp2 = next_pos_reg;
            np2 = np1;
            rc2 = 8'd1;
        end

        if (frame_last) begin
            job.mask[cfe_pkg::SLOT_FINAL] = 1'b1;
            job.mask[cfe_pkg::SLOT_TRAIL] = 1'b1;
            job.final_addr = cp2;
            job.final_code = rc2;
            job.trail_addr = np2;
            job.trail_byte = delimiter;
            job.trail_len  = cfe_pkg::sat_inc(np2, POS_LIMIT);
        end

        code_pos_next = frame_last ? '0 : cp2;
        next_pos_next = frame_last ? 13'd1 : np2;
        run_cnt_next  = frame_last ? 8'd1 : rc2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_pos_reg <= '0;
            next_pos_reg <= 13'd1;
            run_cnt_reg  <= 8'd1;
        end else if (accept) begin
            code_pos_reg <= code_pos_next;
            next_pos_reg <= next_pos_next;
            run_cnt_reg  <= run_cnt_next;
        end
    end

endmodule

[src/cfe_queue.sv]
// Short job queue between the front and back ends of the COBS frame encoder.
// Register-based FIFO of job records. Depends on cfe_pkg.
module cfe_queue #(
    parameter int DEPTH = cfe_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cfe_pkg::job_t push_job,
    input  logic          pop,
    output cfe_pkg::job_t head_job,
    output logic          not_empty,
    output logic          not_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cfe_pkg::job_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign not_empty = (count_reg != '0);
    assign not_full  = (count_reg != CNT_W'(DEPTH));
    assign head_job  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[src/cfe_back.sv]
// Back end of the COBS frame encoder: walks the writes of the head job, one per
// cycle while the output is not stalled, into the output register. Depends on cfe_pkg.
module cfe_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cfe_pkg::job_t              head_job,
    input  logic                       head_valid,
    output logic                       pop,
    input  logic [cfe_pkg::POS_W:0]    eff_cap,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [cfe_pkg::POS_W-1:0]  out_addr,
    output logic [cfe_pkg::BYTE_W-1:0] out_byte,
    output logic                       out_over,
    output logic                       out_done,
    output logic [cfe_pkg::POS_W-1:0]  out_len,
    output logic                       out_last
);

    logic [cfe_pkg::SLOTS-1:0]  done_reg, done_next;
    logic [cfe_pkg::SLOTS-1:0]  pending, sel, rest;
    logic                       take;

    logic                       valid_reg;
    logic [cfe_pkg::POS_W-1:0]  addr_reg, addr_next;
    logic [cfe_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                       over_reg;
    logic                       fdone_reg, fdone_next;
    logic [cfe_pkg::POS_W-1:0]  len_reg, len_next;
    logic                       last_reg;

    always_comb begin
        pending = head_job.mask & ~done_reg;
        sel     = pending & (~pending + 1'b1);
        rest    = pending & ~sel;
        take    = head_valid && (!valid_reg || out_ready);
        pop     = take && (rest == '0);
        done_next = done_reg;
        if (take) begin
            done_next = pop ? '0 : (done_reg | sel);
        end

        addr_next  = head_job.data_addr;
        byte_next  = head_job.data_byte;
        fdone_next = 1'b0;
        len_next   = '0;
        if (sel[cfe_pkg::SLOT_PATCH]) begin
            addr_next = head_job.patch_addr;
            byte_next = head_job.patch_code;
        end else if (sel[cfe_pkg::SLOT_FINAL]) begin
            addr_next = head_job.final_addr;
            byte_next = head_job.final_code;
        end else if (sel[cfe_pkg::SLOT_TRAIL]) begin
            addr_next  = head_job.trail_addr;
            byte_next  = head_job.trail_byte;
            fdone_next = 1'b1;
            len_next   = head_job.trail_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
            if (take) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            addr_reg  <= addr_next;
            byte_reg  <= byte_next;
            over_reg  <= ({1'b0, addr_next} >= eff_cap);
            fdone_reg <= fdone_next;
            len_reg   <= len_next;
            last_reg  <= (rest == '0);
        end
    end

    assign out_valid = valid_reg;
    assign out_addr  = addr_reg;
    assign out_byte  = byte_reg;
    assign out_over  = over_reg;
    assign out_done  = fdone_reg;
    assign out_len   = len_reg;
    assign out_last  = last_reg;

endmodule

[src/cobs_frame_encoder.sv]
// COBS frame encoder top level. An accepted byte is stored as a job in the queue, and
// its first write is then registered into the master-side output register. Throughput:
// one byte per cycle while each byte makes one write and the output is not stalled;
// the output side drains one write per cycle while m_tready is high, so a byte that
// fills a run or ends a frame makes two to four writes there, and a four-entry job
// queue absorbs those bursts. Reset is synchronous (aresetn low) and clears the encoder
// state, the queue and the output valid; no clearing pass.
module cobs_frame_encoder #(
    parameter int BUFFER_DEPTH = cfe_pkg::DEFAULT_BUFFER_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input beats.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // [7:0] data_byte
    input  logic                                s_tlast,  // frame_last
    // Result beats.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [12:0] write_address, [20:13] write_byte, [33:21] encoded_length, [39:34] zero
    output logic [cfe_pkg::TDATA_OUT_W-1:0]     m_tdata,
    output logic [1:0]                          m_tuser,  // [0] over_capacity, [1] frame_done
    output logic                                m_tlast,  // run_last
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cfe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cfe_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam logic [cfe_pkg::POS_W-1:0] POS_LIMIT =
        (BUFFER_DEPTH < 8191) ? cfe_pkg::POS_W'(BUFFER_DEPTH) : 13'd8191;
    localparam logic [cfe_pkg::POS_W:0] DEPTH_CAP =
        (BUFFER_DEPTH > 8191) ? 14'd8192 : 14'(BUFFER_DEPTH);

    logic [cfe_pkg::BYTE_W-1:0] delimiter_reg;
    logic [cfe_pkg::BYTE_W-1:0] max_count_reg;
    logic [cfe_pkg::POS_W-1:0]  out_capacity_reg;
    logic [cfe_pkg::POS_W:0]    eff_cap;

    cfe_pkg::job_t front_job, head_job;
    logic          s_accept;
    logic          q_not_empty, q_not_full, q_pop;

    logic [cfe_pkg::POS_W-1:0]  w_addr, w_len;
    logic [cfe_pkg::BYTE_W-1:0] w_byte;
    logic                       w_over, w_done, w_last;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delimiter_reg    <= cfe_pkg::RST_DELIMITER;
            max_count_reg    <= cfe_pkg::RST_MAX_COUNT;
            out_capacity_reg <= cfe_pkg::RST_OUT_CAPACITY;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                cfe_pkg::CFG_DELIMITER:    delimiter_reg    <= cfg_data[7:0];
                cfe_pkg::CFG_MAX_COUNT:    max_count_reg    <= cfg_data[7:0];
                cfe_pkg::CFG_OUT_CAPACITY: out_capacity_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_cap = ({1'b0, out_capacity_reg} < DEPTH_CAP) ? {1'b0, out_capacity_reg}
                                                              : DEPTH_CAP;

    assign s_tready = q_not_full;
    assign s_accept = s_tvalid && s_tready;

    cfe_front #(
        .POS_LIMIT (POS_LIMIT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (s_accept),
        .data_byte  (s_tdata),
        .frame_last (s_tlast),
        .delimiter  (delimiter_reg),
        .max_count  (max_count_reg),
        .job        (front_job)
    );

    cfe_queue #(
        .DEPTH (cfe_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_accept),
        .push_job  (front_job),
        .pop       (q_pop),
        .head_job  (head_job),
        .not_empty (q_not_empty),
        .not_full  (q_not_full)
    );

    cfe_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_job   (head_job),
        .head_valid (q_not_empty),
        .pop        (q_pop),
        .eff_cap    (eff_cap),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_addr   (w_addr),
        .out_byte   (w_byte),
        .out_over   (w_over),
        .out_done   (w_done),
        .out_len    (w_len),
        .out_last   (w_last)
    );

    assign m_tdata = {6'd0, w_len, w_byte, w_addr};
    assign m_tuser = {w_done, w_over};
    assign m_tlast = w_last;

    // The trailer is always the last write of its byte.
    a_done_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tlast)
        else $error("frame_done beat without run_last");

    // A finished frame holds at least one code byte and the trailer.
    a_len_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata[33:21] >= 13'd2))
        else $error("encoded length below two");

    // Length is reported only with the trailer.
    a_len_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[33:21] == 13'd0))
        else $error("encoded length on a non-trailer beat");

    // The queue never drains a job that was never pushed.
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_not_empty)
        else $error("queue pop while empty");

endmodule

[tb/cobs_frame_encoder_tb.sv]
// Self-checking testbench for the COBS frame encoder (cobs_frame_encoder).
// Predicts every buffer write from the accepted bytes and checks each result beat in order.
// Depends on cfe_pkg and the encoder RTL only.
`timescale 1ns / 100ps

module cobs_frame_encoder_tb;

    // Positions saturate at the smaller of BUFFER_DEPTH and 8191.
    localparam int POS_CEIL = cfe_pkg::DEFAULT_BUFFER_DEPTH;
    localparam logic [cfe_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int MAX_REPORTS = 50;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_GUARD = 5000;
    localparam int RANDOM_ITEMS = 84;

    typedef enum int {PACE_FREE, PACE_SENDER, PACE_RECEIVER, PACE_BOTH} pace_t;

    typedef struct packed {
        logic [cfe_pkg::POS_W-1:0]  addr;
        logic [cfe_pkg::BYTE_W-1:0] wbyte;
        logic                       over;
        logic                       done;
        logic [cfe_pkg::POS_W-1:0]  len;
        logic                       run_last;
    } buf_write_t;

    class stuffing_scoreboard;
        logic [7:0]  delim_cfg;
        logic [7:0]  max_cfg;
        logic [12:0] cap_cfg;
        int          code_pos;
        int          run_cnt;
        int          next_pos;
        buf_write_t  pending[$];
        buf_write_t  held;
        bit          has_held;
        int          mismatches;

        function new();
            delim_cfg  = cfe_pkg::RST_DELIMITER;
            max_cfg    = cfe_pkg::RST_MAX_COUNT;
            cap_cfg    = cfe_pkg::RST_OUT_CAPACITY;
            code_pos   = 0;
            run_cnt    = 1;
            next_pos   = 1;
            has_held   = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [cfe_pkg::CFG_IDX_W-1:0] idx,
                              logic [cfe_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                cfe_pkg::CFG_DELIMITER:    delim_cfg = val[7:0];
                cfe_pkg::CFG_MAX_COUNT:    max_cfg = val[7:0];
                cfe_pkg::CFG_OUT_CAPACITY: cap_cfg = val;
                default: ;
            endcase
        endfunction

        function int clamp_pos(int p);
            return (p > POS_CEIL) ? POS_CEIL : p;
        endfunction

        // The newest write is held back so that the last one of a byte can be marked.
        function void queue_write(int addr, logic [7:0] b, logic d, int len);
            int a;
            int cap;
            a = clamp_pos(addr);
            cap = (cap_cfg > POS_CEIL) ? POS_CEIL : int'(cap_cfg);
            if (has_held) pending.push_back(held);
            held.addr     = a[cfe_pkg::POS_W-1:0];
            held.wbyte    = b;
            held.over     = (a >= cap);
            held.done     = d;
            held.len      = len[cfe_pkg::POS_W-1:0];
            held.run_last = 1'b0;
            has_held      = 1'b1;
        endfunction

        function void close_block(int code);
            queue_write(code_pos, code[7:0], 1'b0, 0);
            code_pos = next_pos;
            next_pos = clamp_pos(next_pos + 1);
            run_cnt  = 1;
        endfunction

        function void take_byte(logic [7:0] b, logic fin);
            int lim;
            lim = (max_cfg < 2) ? 255 : int'(max_cfg);
            if (b != delim_cfg) begin
                queue_write(next_pos, b, 1'b0, 0);
                next_pos = clamp_pos(next_pos + 1);
                run_cnt  = (run_cnt + 1) & 255;
                // A run already past a lowered max count closes here with its true count.
                if (run_cnt >= lim) close_block(run_cnt);
            end else begin
                close_block(run_cnt);
            end
            if (fin) begin
                queue_write(code_pos, run_cnt[7:0], 1'b0, 0);
                queue_write(next_pos, delim_cfg, 1'b1, clamp_pos(next_pos + 1));
                code_pos = 0;
                run_cnt  = 1;
                next_pos = 1;
            end
            held.run_last = 1'b1;
            pending.push_back(held);
            has_held = 1'b0;
        endfunction

        function void compare(string field, logic [31:0] exp, logic [31:0] act);
            if (exp !== act) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("%s: expected %0d, got %0d", field, exp, act);
            end
        endfunction

        function void check_write(logic [cfe_pkg::TDATA_OUT_W-1:0] td, logic [1:0] tu,
                                  logic tl);
            buf_write_t w;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("write beat with nothing expected: tdata %h", td);
                return;
            end
            w = pending.pop_front();
            compare("write_address", 32'(w.addr), 32'(td[12:0]));
            compare("write_byte", 32'(w.wbyte), 32'(td[20:13]));
            compare("encoded_length", 32'(w.len), 32'(td[33:21]));
            compare("tdata padding", 32'd0, 32'(td[cfe_pkg::TDATA_OUT_W-1:34]));
            compare("over_capacity", 32'(w.over), 32'(tu[0]));
            compare("frame_done", 32'(w.done), 32'(tu[1]));
            compare("run_last", 32'(w.run_last), 32'(tl));
        endfunction
    endclass

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [7:0]                         s_tdata   = '0;
    logic                               s_tlast   = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [cfe_pkg::TDATA_OUT_W-1:0]    m_tdata;
    logic [1:0]                         m_tuser;
    logic                               m_tlast;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [cfe_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [cfe_pkg::CFG_DATA_W-1:0]     cfg_data  = '0;

    int idle_pct  = 0;
    int stall_pct = 0;
    stuffing_scoreboard sb;

    cobs_frame_encoder dut (.*);

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_write(m_tdata, m_tuser, m_tlast);
        end
    end

    task automatic set_pace(input pace_t p);
        case (p)
            PACE_FREE: begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            PACE_SENDER: begin
                idle_pct  = 63;
                stall_pct = 0;
            end
            PACE_RECEIVER: begin
                idle_pct  = 0;
                stall_pct = 63;
            end
            default: begin
                idle_pct  = 16;
                stall_pct = 16;
            end
        endcase
    endtask

    // Leaves tvalid high after the beat so that back-to-back bytes need no toggle.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.take_byte(b, fin);
    endtask

    function automatic logic [7:0] pick_byte(int delim_pct);
        logic [7:0] b;
        if ($urandom_range(0, 99) < delim_pct) return sb.delim_cfg;
        b = 8'($urandom);
        while (b == sb.delim_cfg) b = 8'($urandom);
        return b;
    endfunction

    task automatic send_run(input int count, input int delim_pct, input bit closed);
        for (int i = 0; i < count; i++) begin
            send_byte(pick_byte(delim_pct), closed && (i == count - 1));
        end
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (sb.pending.size() > 0 && waited < DRAIN_GUARD) begin
            @(posedge aclk);
            waited++;
        end
        if (sb.pending.size() > 0) begin
            sb.mismatches++;
            $error("%0d expected writes never arrived", sb.pending.size());
            sb.pending.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [cfe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cfe_pkg::CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    // The spare index is written too; the encoder must ignore it.
    task automatic configure(input logic [7:0] delim, input logic [7:0] maxc,
                             input logic [12:0] cap);
        write_reg(cfe_pkg::CFG_DELIMITER, {5'd0, delim});
        write_reg(cfe_pkg::CFG_MAX_COUNT, {5'd0, maxc});
        write_reg(cfe_pkg::CFG_OUT_CAPACITY, cap);
        write_reg(CFG_SPARE, 13'($urandom));
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure_random();
        logic [7:0]  delim;
        logic [7:0]  maxc;
        logic [12:0] cap;
        case ($urandom_range(0, 3))
            0:       delim = 8'h00;
            1:       delim = 8'hFF;
            default: delim = 8'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       maxc = 8'($urandom_range(0, 1));
            1:       maxc = 8'd2;
            2:       maxc = 8'd255;
            3:       maxc = 8'($urandom_range(3, 8));
            default: maxc = 8'($urandom_range(2, 255));
        endcase
        case ($urandom_range(0, 4))
            0:       cap = 13'($urandom_range(0, 40));
            1:       cap = 13'd4096;
            2:       cap = 13'($urandom_range(4097, 8191));
            default: cap = 13'($urandom_range(2, 4096));
        endcase
        configure(delim, maxc, cap);
    endtask

    initial begin
        int random_items;
        int phase;
        int budget;
        int flen;
        bit closed;
        random_items = 0;
        phase = 0;
        sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: delimiter zero, max count 255, full capacity.
        set_pace(PACE_FREE);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h33, 1'b1);
        drain();

        // Smallest max count and a capacity of two: most writes land beyond the capacity.
        configure(8'hFF, 8'd2, 13'd2);
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7F, 1'b1);
        drain();

        // Max counts below two behave as 255; capacity above the buffer is clipped.
        configure(8'h5A, 8'd0, 13'd8191);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h01, 1'b1);
        drain();
        configure(8'h5A, 8'd1, 13'd0);
        send_byte(8'h02, 1'b0);
        send_byte(8'hA5, 1'b1);
        drain();

        // Lower the max count while a long run is open.
        configure(8'h00, 8'd255, 13'd4096);
        send_run(10, 0, 1'b0);
        drain();
        configure(8'h00, 8'd3, 13'd4096);
        send_byte(8'h0B, 1'b0);
        send_byte(8'h0C, 1'b1);
        drain();

        // A run long enough to close a full 255 block.
        configure(8'h00, 8'd255, 13'd4096);
        send_run(260, 0, 1'b1);
        drain();

        while (random_items < RANDOM_ITEMS) begin
            configure_random();
            set_pace(pace_t'(phase % 4));
            budget = $urandom_range(18, 24);
            while (budget > 0 && random_items < RANDOM_ITEMS) begin
                flen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 120)
                                                   : $urandom_range(1, 16);
                if (flen > budget) flen = budget;
                // Phases may end inside a frame so that new settings meet an open run.
                closed = (flen < budget) || $urandom_range(0, 1);
                send_run(flen, $urandom_range(0, 30), closed);
                budget -= flen;
                random_items += flen;
            end
            drain();
            phase++;
        end

        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
